// ----- hw/rtl/ipre_pkg.sv -----
// shared types and constants for the indexed pixel row expander
`default_nettype none

package ipre_pkg;

  // item operation codes
  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_DATA    = 1'b1
  } ipre_op_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_BPP    = 3'd0,
    CFG_WIDTH  = 3'd1,
    CFG_HEIGHT = 3'd2,
    CFG_COLORS = 3'd3,
    CFG_SINGLE = 3'd4
  } ipre_cfg_e;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  // supported index widths
  localparam logic [3:0] BPP_1 = 4'd1;
  localparam logic [3:0] BPP_4 = 4'd4;
  localparam logic [3:0] BPP_8 = 4'd8;

  // largest row count per image
  localparam int MAX_ROWS = 4096;

  // configuration register contents
  typedef struct packed {
    logic [3:0]  bpp;
    logic [12:0] width;
    logic [12:0] height;
    logic [8:0]  colors;
    logic        single;
  } ipre_cfg_t;

  // per-pixel sideband travelling with a palette lookup
  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row_number;
    logic        last_of_byte;
    logic        end_of_row;
    logic        end_of_image;
  } ipre_pix_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ipre_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module ipre_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ipre_unpack.sv -----
// row byte counting and per-pixel index extraction for the row expander
`default_nettype none

module ipre_unpack import ipre_pkg::*; #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ipre_cfg_t  cfg_i,
  input  wire logic       byte_acc_i,
  input  wire logic [7:0] data_byte_i,
  output logic            byte_ready_o,
  output logic            pix_valid_o,
  output logic [7:0]      pix_idx_o,
  output ipre_pix_t       pix_info_o,
  input  wire logic       pix_take_i
);

  // widest effective row, limited by the 13-bit width register
  localparam int WMAX = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
  localparam int PW   = $clog2(WMAX + 1);
  localparam int BW   = PW + 1;
  localparam int CW   = PW + 4;

  // row position counters
  logic [BW-1:0] byte_cnt_q, byte_cnt_d;
  logic [PW-1:0] pix_cnt_q, pix_cnt_d;
  logic [11:0]   row_cnt_q, row_cnt_d;

  // byte being expanded
  logic          u_valid_q, u_valid_d;
  logic [7:0]    u_byte_q, u_byte_d;
  logic [3:0]    u_rem_q, u_rem_d;
  logic [PW-1:0] u_col_q, u_col_d;
  logic [11:0]   u_row_q, u_row_d;

  // derived geometry
  logic          bpp_ok;
  logic [PW-1:0] eff_w;
  logic [PW-1:0] eff_w_m1;
  logic [12:0]   eff_h;
  logic [11:0]   eff_h_m1;
  logic [CW-1:0] bits;
  logic [CW-1:0] used;
  logic [CW-1:0] stride;
  logic [3:0]    per_byte;
  logic [8:0]    pal_n;
  logic [7:0]    lim_m1;
  logic [PW-1:0] pix_left;
  logic [3:0]    cnt;
  logic [CW-1:0] byte_inc;
  logic [12:0]   row_inc;
  logic [7:0]    raw_idx;
  logic          last_pix;

  // geometry from the configuration registers
  always_comb begin
    bpp_ok = (cfg_i.bpp == BPP_1) || (cfg_i.bpp == BPP_4) || (cfg_i.bpp == BPP_8);

    if (cfg_i.width == 13'd0) begin
      eff_w = PW'(1);
    end else if (cfg_i.width > 13'(WMAX)) begin
      eff_w = PW'(WMAX);
    end else begin
      eff_w = cfg_i.width[PW-1:0];
    end
    eff_w_m1 = eff_w - PW'(1);

    if (cfg_i.height == 13'd0) begin
      eff_h = 13'd1;
    end else if (cfg_i.height > 13'(MAX_ROWS)) begin
      eff_h = 13'(MAX_ROWS);
    end else begin
      eff_h = cfg_i.height;
    end
    eff_h_m1 = 12'(eff_h - 13'd1);

    case (cfg_i.bpp)
      BPP_1: begin
        bits     = CW'(eff_w);
        per_byte = 4'd8;
        pal_n    = 9'd2;
      end
      BPP_4: begin
        bits     = CW'(eff_w) << 2;
        per_byte = 4'd2;
        pal_n    = 9'd16;
      end
      default: begin
        bits     = CW'(eff_w) << 3;
        per_byte = 4'd1;
        pal_n    = 9'd256;
      end
    endcase

    used   = (bits + CW'(7)) >> 3;
    stride = ((bits + CW'(31)) >> 5) << 2;

    // active palette size
    if (cfg_i.colors != 9'd0 && cfg_i.colors <= pal_n) begin
      pal_n = cfg_i.colors;
    end
    if (pal_n > 9'(PALETTE_DEPTH)) begin
      pal_n = 9'(PALETTE_DEPTH);
    end
    lim_m1 = 8'(pal_n - 9'd1);
  end

  // pixels carried by the incoming byte and counter advance
  always_comb begin
    pix_left = eff_w - pix_cnt_q;
    cnt      = 4'd0;
    if (CW'(byte_cnt_q) < used && pix_cnt_q < eff_w) begin
      if (pix_left < PW'(per_byte)) begin
        cnt = 4'(pix_left);
      end else begin
        cnt = per_byte;
      end
    end
    byte_inc = CW'(byte_cnt_q) + CW'(1);
    row_inc  = 13'(row_cnt_q) + 13'd1;
  end

  // index of the current pixel, most significant first, clamped
  always_comb begin
    case (cfg_i.bpp)
      BPP_1:   raw_idx = {7'd0, u_byte_q[7]};
      BPP_4:   raw_idx = {4'd0, u_byte_q[7:4]};
      default: raw_idx = u_byte_q;
    endcase
    if (raw_idx > lim_m1) begin
      pix_idx_o = lim_m1;
    end else begin
      pix_idx_o = raw_idx;
    end
  end

  // sideband for the current pixel
  always_comb begin
    last_pix                 = (u_rem_q == 4'd1);
    pix_valid_o              = u_valid_q;
    pix_info_o.column        = 12'(u_col_q);
    pix_info_o.row_number    = u_row_q;
    pix_info_o.last_of_byte  = last_pix;
    pix_info_o.end_of_row    = (u_col_q == eff_w_m1);
    pix_info_o.end_of_image  = (u_col_q == eff_w_m1) && (u_row_q == eff_h_m1);
    byte_ready_o             = !u_valid_q || (pix_take_i && last_pix);
  end

  // next state of counters and the expansion register
  always_comb begin
    byte_cnt_d = byte_cnt_q;
    pix_cnt_d  = pix_cnt_q;
    row_cnt_d  = row_cnt_q;
    u_valid_d  = u_valid_q;
    u_byte_d   = u_byte_q;
    u_rem_d    = u_rem_q;
    u_col_d    = u_col_q;
    u_row_d    = u_row_q;

    // step to the next pixel of the byte
    if (pix_take_i) begin
      u_byte_d = u_byte_q << cfg_i.bpp;
      u_rem_d  = u_rem_q - 4'd1;
      u_col_d  = u_col_q + PW'(1);
      if (last_pix) begin
        u_valid_d = 1'b0;
      end
    end

    // a new byte with a valid index width
    if (byte_acc_i && bpp_ok) begin
      pix_cnt_d = pix_cnt_q + PW'(cnt);
      if (byte_inc >= stride) begin
        byte_cnt_d = '0;
        pix_cnt_d  = '0;
        if (row_inc >= eff_h) begin
          row_cnt_d = '0;
        end else begin
          row_cnt_d = row_inc[11:0];
        end
      end else begin
        byte_cnt_d = byte_inc[BW-1:0];
      end
      if (cnt != 4'd0) begin
        u_valid_d = 1'b1;
        u_byte_d  = data_byte_i;
        u_rem_d   = cnt;
        u_col_d   = pix_cnt_q;
        u_row_d   = row_cnt_q;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      pix_cnt_q  <= '0;
      row_cnt_q  <= '0;
      u_valid_q  <= 1'b0;
    end else begin
      byte_cnt_q <= byte_cnt_d;
      pix_cnt_q  <= pix_cnt_d;
      row_cnt_q  <= row_cnt_d;
      u_valid_q  <= u_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    u_byte_q <= u_byte_d;
    u_rem_q  <= u_rem_d;
    u_col_q  <= u_col_d;
    u_row_q  <= u_row_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ipre_out_stage.sv -----
// result register beside the palette read data, with output handshake
`default_nettype none

module ipre_out_stage import ipre_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pix_valid_i,
  input  wire ipre_pix_t   pix_info_i,
  output logic             pix_take_o,
  input  wire logic        single_i,
  input  wire logic [23:0] rdata_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       pixel_blue_o,
  output logic [7:0]       pixel_green_o,
  output logic [7:0]       pixel_red_o,
  output ipre_pix_t        info_o
);

  logic      valid_q, valid_d;
  ipre_pix_t info_q;

  // a lookup is issued when the result slot is free or draining
  assign pix_take_o = pix_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (pix_take_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_take_o) begin
      info_q <= pix_info_i;
    end
  end

  // color split, gray keeps blue only
  assign out_valid_o   = valid_q;
  assign pixel_blue_o  = rdata_i[7:0];
  assign pixel_green_o = single_i ? 8'd0 : rdata_i[15:8];
  assign pixel_red_o   = single_i ? 8'd0 : rdata_i[23:16];
  assign info_o        = info_q;

endmodule

`default_nettype wire

// ----- hw/rtl/indexed_pixel_row_expander.sv -----
// top level of the indexed pixel row expander
`default_nettype none

// Expands bottom-up bitmap rows of 1, 4 or 8 bit palette indices into pixels.
// An item with op 0 writes one palette entry and yields nothing; an item with
// op 1 carries one raw row byte, and pad bytes up to the 32-bit row stride only
// advance the byte count. Indices leave most significant first, clamped to the
// active palette size and looked up in a palette ram with one write and one
// read port; pixels come out one per cycle while pixel bytes keep coming and
// the output is not stalled. A byte yields one pixel at 8 bpp, two at 4 bpp,
// up to eight at 1 bpp; palette writes and pad bytes yield none. The next item
// is accepted in the cycle the previous byte's last pixel enters the palette
// read; a byte's first pixel passes the expansion register, then the result
// register. The user must write configuration through a separate port only
// while the block is idle, unenforced by the block; cfg_ready_o is always high.

module indexed_pixel_row_expander import ipre_pkg::*; #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration writes
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input items
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   op_i,
  input  wire logic [7:0]             palette_index_i,
  input  wire logic [7:0]             entry_blue_i,
  input  wire logic [7:0]             entry_green_i,
  input  wire logic [7:0]             entry_red_i,
  input  wire logic [7:0]             data_byte_i,
  // result items
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [7:0]                  pixel_blue_o,
  output logic [7:0]                  pixel_green_o,
  output logic [7:0]                  pixel_red_o,
  output logic [11:0]                 column_o,
  output logic [11:0]                 row_number_o,
  output logic                        last_of_byte_o,
  output logic                        end_of_row_o,
  output logic                        end_of_image_o
);

  localparam int AW = $clog2(PALETTE_DEPTH > 1 ? PALETTE_DEPTH : 2);

  ipre_cfg_t  cfg_q;
  logic       in_acc;
  logic       byte_acc;
  logic       pal_we;
  logic       byte_ready;
  logic       pix_valid;
  logic [7:0] pix_idx;
  ipre_pix_t  pix_info;
  logic       pix_take;
  logic [23:0] rdata;
  ipre_pix_t  out_info;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpp    <= BPP_8;
      cfg_q.width  <= 13'd1;
      cfg_q.height <= 13'd1;
      cfg_q.colors <= 9'd0;
      cfg_q.single <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BPP:    cfg_q.bpp    <= cfg_data_i[3:0];
        CFG_WIDTH:  cfg_q.width  <= cfg_data_i[12:0];
        CFG_HEIGHT: cfg_q.height <= cfg_data_i[12:0];
        CFG_COLORS: cfg_q.colors <= cfg_data_i[8:0];
        CFG_SINGLE: cfg_q.single <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input item decode
  assign in_ready_o = byte_ready;
  assign in_acc     = in_valid_i && in_ready_o;
  assign byte_acc   = in_acc && (op_i == OP_DATA);
  assign pal_we     = in_acc && (op_i == OP_PALETTE) &&
                      ({1'b0, palette_index_i} < 9'(PALETTE_DEPTH));

  ipre_unpack #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_unpack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .byte_acc_i   (byte_acc),
    .data_byte_i  (data_byte_i),
    .byte_ready_o (byte_ready),
    .pix_valid_o  (pix_valid),
    .pix_idx_o    (pix_idx),
    .pix_info_o   (pix_info),
    .pix_take_i   (pix_take)
  );

  // palette table: red high, green, blue low
  ipre_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (palette_index_i[AW-1:0]),
    .wdata_i ({entry_red_i, entry_green_i, entry_blue_i}),
    .re_i    (pix_take),
    .raddr_i (pix_idx[AW-1:0]),
    .rdata_o (rdata)
  );

  ipre_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_valid_i   (pix_valid),
    .pix_info_i    (pix_info),
    .pix_take_o    (pix_take),
    .single_i      (cfg_q.single),
    .rdata_i       (rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_blue_o  (pixel_blue_o),
    .pixel_green_o (pixel_green_o),
    .pixel_red_o   (pixel_red_o),
    .info_o        (out_info)
  );

  // result sideband
  assign column_o       = out_info.column;
  assign row_number_o   = out_info.row_number;
  assign last_of_byte_o = out_info.last_of_byte;
  assign end_of_row_o   = out_info.end_of_row;
  assign end_of_image_o = out_info.end_of_image;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for the indexed pixel row expander
import ipre_pkg::*;

localparam int unsigned MAX_PIXELS   = 4096;
localparam int unsigned PALETTE_SIZE = 256;

// one pixel as it leaves the block
typedef struct packed {
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [11:0] column;
  logic [11:0] row_number;
  logic        last_of_byte;
  logic        end_of_row;
  logic        end_of_image;
} pixel_t;

// expected pixels and the row and palette state behind them
class expander_scoreboard;
  bit [23:0]   palette [PALETTE_SIZE];  // red high, green, blue low
  bit [3:0]    bpp    = BPP_8;
  bit [12:0]   width  = 13'd1;
  bit [12:0]   height = 13'd1;
  bit [8:0]    colors;
  bit          single;
  int unsigned byte_in_row, pixel_in_row, row_counter;
  pixel_t      pending_pixels [$];
  int unsigned errors, checked, row_ends, image_ends;

  // register write, masked to the register width
  function void set_register(logic [2:0] index, logic [12:0] value);
    case (ipre_cfg_e'(index))
      CFG_BPP:    bpp = value[3:0];
      CFG_WIDTH:  width = value;
      CFG_HEIGHT: height = value;
      CFG_COLORS: colors = value[8:0];
      CFG_SINGLE: single = value[0];
      default: ;
    endcase
  endfunction

  function bit bpp_ok();
    return bpp == BPP_1 || bpp == BPP_4 || bpp == BPP_8;
  endfunction

  function int unsigned active_width();
    if (width == 0) return 1;
    if (width > MAX_PIXELS) return MAX_PIXELS;
    return int'(width);
  endfunction

  function int unsigned active_height();
    if (height == 0) return 1;
    if (height > MAX_ROWS) return MAX_ROWS;
    return int'(height);
  endfunction

  function int unsigned row_stride();
    return (int'(bpp) * active_width() + 31) / 32 * 4;
  endfunction

  // colors in use: declared count, else the full index range
  function int unsigned palette_limit();
    int unsigned n;
    n = 1 << bpp;
    if (colors != 0 && colors <= n) n = int'(colors);
    if (n > PALETTE_SIZE) n = PALETTE_SIZE;
    return n;
  endfunction

  // k-th index of a byte, most significant first, clamped to the palette
  function int unsigned pick_index(bit [7:0] data, int unsigned k);
    int unsigned idx;
    idx = (int'(data) >> (8 - int'(bpp) * (k + 1))) & ((1 << bpp) - 1);
    if (idx >= palette_limit()) idx = palette_limit() - 1;
    return idx;
  endfunction

  // accepted item: palette write, or a row byte expanded into pixels
  function void accept_item(ipre_op_e op, bit [7:0] index, bit [7:0] blue,
                            bit [7:0] green, bit [7:0] red, bit [7:0] data);
    int unsigned w, h, used, per, count, col, idx;
    pixel_t px;
    if (op == OP_PALETTE) begin
      palette[index] = {red, green, blue};
      return;
    end
    if (!bpp_ok()) return;
    w = active_width();
    h = active_height();
    used = (int'(bpp) * w + 7) / 8;
    per = 8 / int'(bpp);
    count = 0;
    if (byte_in_row < used && pixel_in_row < w) begin
      count = w - pixel_in_row;
      if (count > per) count = per;
    end
    for (int unsigned k = 0; k < count; k++) begin
      idx = pick_index(data, k);
      col = pixel_in_row + k;
      px.blue         = palette[idx][7:0];
      px.green        = single ? 8'd0 : palette[idx][15:8];
      px.red          = single ? 8'd0 : palette[idx][23:16];
      px.column       = col[11:0];
      px.row_number   = row_counter[11:0];
      px.last_of_byte = (k + 1 == count);
      px.end_of_row   = (col == w - 1);
      px.end_of_image = (col == w - 1) && (row_counter == h - 1);
      pending_pixels.push_back(px);
    end
    pixel_in_row += count;
    // stride reached: row ends, row counter wraps past the last row
    byte_in_row++;
    if (byte_in_row >= row_stride()) begin
      byte_in_row = 0;
      pixel_in_row = 0;
      row_counter++;
      if (row_counter >= h) row_counter = 0;
    end
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // pixel from the block against the oldest expected one
  function void check_pixel(pixel_t got);
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      $error("pixel with none expected: column %0d row %0d", got.column, got.row_number);
      errors++;
      return;
    end
    want = pending_pixels.pop_front();
    compare_field("pixel_blue", want.blue, got.blue);
    compare_field("pixel_green", want.green, got.green);
    compare_field("pixel_red", want.red, got.red);
    compare_field("column", want.column, got.column);
    compare_field("row_number", want.row_number, got.row_number);
    compare_field("last_of_byte", want.last_of_byte, got.last_of_byte);
    compare_field("end_of_row", want.end_of_row, got.end_of_row);
    compare_field("end_of_image", want.end_of_image, got.end_of_image);
    checked++;
    if (got.end_of_row) row_ends++;
    if (got.end_of_image) image_ends++;
  endfunction
endclass

module testbench;
  localparam int unsigned RANDOM_ITEMS  = 460;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i      = '0;
  logic                   in_valid_i      = 1'b0;
  logic                   in_ready_o;
  logic                   op_i            = 1'b0;
  logic [7:0]             palette_index_i = '0;
  logic [7:0]             entry_blue_i    = '0;
  logic [7:0]             entry_green_i   = '0;
  logic [7:0]             entry_red_i     = '0;
  logic [7:0]             data_byte_i     = '0;
  logic                   out_valid_o;
  logic                   out_ready_i     = 1'b0;
  logic [7:0]             pixel_blue_o;
  logic [7:0]             pixel_green_o;
  logic [7:0]             pixel_red_o;
  logic [11:0]            column_o;
  logic [11:0]            row_number_o;
  logic                   last_of_byte_o;
  logic                   end_of_row_o;
  logic                   end_of_image_o;

  expander_scoreboard sb = new();
  bit                 loaded [PALETTE_SIZE];  // palette entries written so far
  int unsigned        idle_pct, stall_pct;
  int unsigned        cycles, items_sent, palette_writes, useful_items, reg_writes;

  indexed_pixel_row_expander dut (.*);

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected",
               cycles, sb.pending_pixels.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // accepted items feed the scoreboard, accepted pixels are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.accept_item(ipre_op_e'(op_i), palette_index_i, entry_blue_i, entry_green_i,
                       entry_red_i, data_byte_i);
      if (out_valid_o && out_ready_i)
        sb.check_pixel(pixel_t'{pixel_blue_o, pixel_green_o, pixel_red_o, column_o,
                                row_number_o, last_of_byte_o, end_of_row_o,
                                end_of_image_o});
    end
  end

  function automatic bit [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // one item, with random sender gaps; returns at the accepting edge
  task automatic send_item(ipre_op_e op, bit [7:0] index, bit [7:0] blue, bit [7:0] green,
                           bit [7:0] red, bit [7:0] data);
    @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    op_i            <= op;
    palette_index_i <= index;
    entry_blue_i    <= blue;
    entry_green_i   <= green;
    entry_red_i     <= red;
    data_byte_i     <= data;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (op == OP_PALETTE || sb.bpp_ok()) useful_items++;
  endtask

  task automatic send_palette(bit [7:0] index, bit [7:0] blue, bit [7:0] green,
                              bit [7:0] red);
    send_item(OP_PALETTE, index, blue, green, red, rand_byte());
    loaded[index] = 1'b1;
    palette_writes++;
  endtask

  // row byte; any entry it could look up is written first
  task automatic send_data(bit [7:0] data);
    int unsigned idx;
    if (sb.bpp_ok()) begin
      for (int unsigned k = 0; k < 8 / int'(sb.bpp); k++) begin
        idx = sb.pick_index(data, k);
        if (!loaded[idx]) send_palette(idx[7:0], rand_byte(), rand_byte(), rand_byte());
      end
    end
    send_item(OP_DATA, rand_byte(), rand_byte(), rand_byte(), rand_byte(), data);
  endtask

  // stop sending until every pixel is out and the pipeline has settled
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write; the item channel is idle meanwhile
  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(index, value);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setup(bit [12:0] bpp_v, bit [12:0] width_v, bit [12:0] height_v,
                             bit [12:0] colors_v, bit [12:0] single_v);
    wait_idle();
    write_reg(CFG_BPP, bpp_v);
    write_reg(CFG_WIDTH, width_v);
    write_reg(CFG_HEIGHT, height_v);
    write_reg(CFG_COLORS, colors_v);
    write_reg(CFG_SINGLE, single_v);
  endtask

  initial begin
    int unsigned first_random, seg, stride, budget;
    bit [12:0]   bpp_v, width_v, height_v, colors_v, single_v;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: 8 bpp, one pixel per row, one row; one pixel then pad bytes
    send_palette(8'h00, 8'h00, 8'h00, 8'h00);
    send_palette(8'hff, 8'hff, 8'hff, 8'hff);
    send_palette(8'h01, 8'h5a, 8'ha5, 8'h3c);
    send_data(8'hff);
    send_data(8'h00);
    send_data(8'h01);
    send_data(8'hff);

    // 1 bpp, ten pixels: a full byte and a short last byte read msb first
    apply_setup(BPP_1, 13'd10, 13'd3, 13'd0, 13'd0);
    send_data(8'ha5);
    send_data(8'hc0);
    send_data(8'h0f);
    send_data(8'hf0);

    // 4 bpp clamped to two colors, gray out; height 0 is one row, row 1 lies past it
    apply_setup(BPP_4, 13'd3, 13'd0, 13'd2, 13'd1);
    send_data(8'h3f);
    send_data(8'h20);
    send_data(8'h00);
    send_data(8'h00);

    // unsupported index widths: bytes are dropped
    apply_setup(13'd0, 13'd0, 13'd8191, 13'd511, 13'd0);
    send_data(8'h12);
    write_reg(CFG_BPP, 13'd15);
    send_data(8'h34);
    write_reg(CFG_UNUSED, '1);

    // widest row started, then width register cleared (one pixel) mid-row past the stride
    apply_setup(BPP_8, 13'd8191, 13'd8191, 13'd511, 13'd0);
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'h01);
    send_data(8'h00);
    send_data(8'hff);
    apply_setup(BPP_8, 13'd0, 13'd1, 13'd256, 13'd0);
    send_data(8'h01);
    send_data(8'hff);

    // random settings, mostly whole rows with random content
    first_random = useful_items;
    seg = 0;
    while (useful_items < first_random + RANDOM_ITEMS) begin
      case (seg % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 87;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 87;
        end
        default: begin
          idle_pct  = 12;
          stall_pct = 12;
        end
      endcase
      case ($urandom_range(9))
        0:       bpp_v = 13'($urandom_range(8191));
        1, 2, 3: bpp_v = BPP_1;
        4, 5, 6: bpp_v = BPP_4;
        default: bpp_v = BPP_8;
      endcase
      width_v  = ($urandom_range(4) == 0) ? 13'($urandom_range(8191))
                                          : 13'($urandom_range(1, 40));
      height_v = ($urandom_range(4) == 0) ? 13'($urandom_range(8191))
                                          : 13'($urandom_range(0, 6));
      case ($urandom_range(3))
        0:       colors_v = 13'd0;
        1:       colors_v = 13'($urandom_range(8191));
        2:       colors_v = 13'd256;
        default: colors_v = 13'($urandom_range(1, 20));
      endcase
      single_v = 13'($urandom_range(($urandom_range(3) == 0) ? 8191 : 1));
      apply_setup(bpp_v, width_v, height_v, colors_v, single_v);

      // whole rows, sometimes a partial one left for the next setting
      if (sb.bpp_ok()) begin
        stride = sb.row_stride();
        budget = $urandom_range(1, 3) * stride;
        if ($urandom_range(3) == 0) budget += $urandom_range(1, stride);
        if (budget > 64) budget = $urandom_range(16, 64);
      end else begin
        budget = $urandom_range(1, 4);
      end
      for (int unsigned i = 0; i < budget; i++) begin
        if ($urandom_range(59) == 0) wait_idle();
        if ($urandom_range(14) == 0)
          send_palette(rand_byte(), rand_byte(), rand_byte(), rand_byte());
        send_data(rand_byte());
      end
      seg++;
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("testbench: %0d items (%0d palette writes) over %0d settings, %0d register writes",
             items_sent, palette_writes, seg + 6, reg_writes);
    $display("testbench: %0d pixels checked, %0d row ends, %0d image ends",
             sb.checked, sb.row_ends, sb.image_ends);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

// ----- indexed_pixel_row_expander.f -----
hw/rtl/ipre_pkg.sv
hw/rtl/ipre_ram.sv
hw/rtl/ipre_unpack.sv
hw/rtl/ipre_out_stage.sv
hw/rtl/indexed_pixel_row_expander.sv
tb/testbench.sv
